[rtl/luma_box_downsample_to_ramp_macros.svh]
// Assertion macros used by the checker file of the luma box downsampler.
`ifndef LUMA_BOX_DOWNSAMPLE_TO_RAMP_MACROS_SVH
`define LUMA_BOX_DOWNSAMPLE_TO_RAMP_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define LBD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define LBD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lbd_pkg.sv]
// Package: constants, register indexes and divider handshake types.
package lbd_pkg;

    localparam int MAX_CELL_COLUMNS = 256;
    localparam int MAX_IMAGE_DIM    = 4096;
    localparam int RAMP_LEVELS      = 70;

    localparam int IMG_W    = $clog2(MAX_IMAGE_DIM) + 1;
    localparam int CCOL_W   = $clog2(MAX_CELL_COLUMNS);
    localparam int CFG_W    = 13;
    localparam int CIDX_W   = 3;
    localparam int COLS_W   = 9;
    localparam int LUMA_W   = 16;
    localparam int SUM_W    = 40;
    localparam int IDX_W    = 7;
    localparam int QB       = $clog2(RAMP_LEVELS);
    localparam int AREA_W   = 2 * IMG_W;
    localparam int DIV_W    = SUM_W + QB + 1;
    localparam int DIV_QW   = IMG_W;
    localparam int STEP_W   = $clog2(DIV_QW + 1);

    localparam int LUMA_R   = 77;
    localparam int LUMA_G   = 150;
    localparam int LUMA_B   = 29;
    localparam int GRAD_SHIFT = 16;
    localparam int BIN_SHIFT  = 14;

    localparam logic [CIDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CIDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CIDX_W-1:0] REG_CELL_COLUMNS  = 3'd2;
    localparam logic [CIDX_W-1:0] REG_CELL_ROWS     = 3'd3;
    localparam logic [CIDX_W-1:0] REG_GRADIENT_MODE = 3'd4;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_QW-1:0] quot;
        logic [DIV_W-1:0]  rem;
    } t_div_rsp;

endpackage

[rtl/lbd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/lbd_div.sv]
// Shared restoring divider: one quotient bit per cycle against a pre-shifted divisor.
module lbd_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lbd_pkg::t_div_req          i_req,
    input  logic [lbd_pkg::DIV_W-1:0]  i_num,
    input  logic [lbd_pkg::DIV_W-1:0]  i_den,
    output lbd_pkg::t_div_rsp          o_rsp
);
    import lbd_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_dsh;
    logic [DIV_QW-1:0] r_quot;
    logic              ge;

    assign ge = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
                r_rem  <= i_num;
                r_dsh  <= i_den;
                r_quot <= '0;
            end else if (r_busy) begin
                if (ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_quot <= {r_quot[DIV_QW-2:0], ge};
                r_dsh  <= r_dsh >> 1;
                r_cnt  <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;
endmodule

[rtl/luma_box_downsample_to_ramp.sv]
// Top level: luma box downsampler with ramp index output.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------------
//  pixel   | in        | i_in_valid / o_in_ready    | i_red i_green i_blue i_frame_start
//  cell    | out       | o_out_valid / i_out_ready  | o_ramp_index o_row_end o_frame_end
//  config  | in        | i_cfg_we (no wait)         | i_cfg_index i_cfg_data
//
// A pixel that closes no cell goes through accept, line-store read and accumulate; one that
// closes a cell adds the result handoff in binary mode, and in gradient mode the multiply,
// the divide and the result handoff: the shared divider yields one quotient bit per cycle.
// After reset and after each write to a mapped register the divider runs two 13-step divides
// for the cell pitch and the pixel port stays not ready.
// A finished cell waits in the output register; the next pixel is taken meanwhile, and
// a following result stalls in its last state until the output register frees.
module luma_box_downsample_to_ramp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_red,
    input  logic [7:0]                    i_green,
    input  logic [7:0]                    i_blue,
    input  logic                          i_frame_start,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [lbd_pkg::IDX_W-1:0]     o_ramp_index,
    output logic                          o_row_end,
    output logic                          o_frame_end,
    input  logic                          i_cfg_we,
    input  logic [lbd_pkg::CIDX_W-1:0]    i_cfg_index,
    input  logic [lbd_pkg::CFG_W-1:0]     i_cfg_data
);
    import lbd_pkg::*;

    // sequencer codes
    localparam logic [3:0] S_PREPW = 4'd0;   // start width / columns divide
    localparam logic [3:0] S_WAITW = 4'd1;
    localparam logic [3:0] S_PREPH = 4'd2;   // start height / rows divide
    localparam logic [3:0] S_WAITH = 4'd3;
    localparam logic [3:0] S_INIT  = 4'd4;   // restart position for cell (0,0)
    localparam logic [3:0] S_IDLE  = 4'd5;
    localparam logic [3:0] S_RD    = 4'd6;   // line store read, cell area
    localparam logic [3:0] S_ACC   = 4'd7;   // add luma, write back, step position
    localparam logic [3:0] S_MUL   = 4'd8;   // sum * levels
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_DWT   = 4'd10;
    localparam logic [3:0] S_RES   = 4'd11;  // hand result to output register

    logic [3:0] r_state;

    // configuration
    logic [IMG_W-1:0]  r_cfg_w, r_cfg_h, r_cfg_r;
    logic [COLS_W-1:0] r_cfg_c;
    logic              r_cfg_grad;

    // clamped sizes
    logic [IMG_W-1:0] eff_w, eff_h, eff_c, eff_r, lim_c, cols_ext;

    always_comb begin
        eff_w = (r_cfg_w == '0) ? IMG_W'(1) :
                (r_cfg_w > IMG_W'(MAX_IMAGE_DIM)) ? IMG_W'(MAX_IMAGE_DIM) : r_cfg_w;
        eff_h = (r_cfg_h == '0) ? IMG_W'(1) :
                (r_cfg_h > IMG_W'(MAX_IMAGE_DIM)) ? IMG_W'(MAX_IMAGE_DIM) : r_cfg_h;
        lim_c = (eff_w > IMG_W'(MAX_CELL_COLUMNS)) ? IMG_W'(MAX_CELL_COLUMNS) : eff_w;
        cols_ext = IMG_W'(r_cfg_c);
        eff_c = (cols_ext == '0) ? IMG_W'(1) : (cols_ext > lim_c) ? lim_c : cols_ext;
        eff_r = (r_cfg_r == '0) ? IMG_W'(1) : (r_cfg_r > eff_h) ? eff_h : r_cfg_r;
    end

    // cell pitch: quotient and remainder of size / cells per axis
    logic [IMG_W-1:0] r_wq, r_wr, r_hq, r_hr;

    // position state
    logic [IMG_W-1:0]  r_pix_col, r_pix_row, r_cell_row;
    logic [CCOL_W-1:0] r_cell_col;
    logic [IMG_W-1:0]  r_col_rem, r_row_rem, r_cw_now, r_ch_now, r_next_col, r_next_row;
    logic [IMG_W-1:0]  n_pix_col, n_pix_row, n_cell_row;
    logic [CCOL_W-1:0] n_cell_col;
    logic [IMG_W-1:0]  n_col_rem, n_row_rem, n_cw_now, n_ch_now, n_next_col, n_next_row;

    // datapath registers
    logic [LUMA_W-1:0] r_luma;
    logic [AREA_W-1:0] r_area;
    logic [SUM_W-1:0]  r_sum;
    logic [DIV_W-1:0]  r_num;
    logic [IDX_W-1:0]  r_idx;
    logic              r_row_end_p, r_frame_end_p;
    logic [MAX_CELL_COLUMNS-1:0] r_valid;

    // output register
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_ramp;
    logic              r_row_end, r_frame_end;

    logic in_acc, pos_step, do_restart, wrap, close_cell, out_free, cfg_hit;
    logic [IMG_W:0] pc1, pr1, col_t, row_t;
    logic           col_ge, row_ge;
    logic [IMG_W-1:0] col_rem_stp, row_rem_stp, cw_stp, ch_stp;

    assign in_acc   = i_in_valid && o_in_ready;
    assign pos_step = (r_state == S_ACC);
    assign out_free = !r_out_valid || i_out_ready;
    assign cfg_hit  = i_cfg_we && (i_cfg_index <= REG_GRADIENT_MODE);

    assign pc1 = {1'b0, r_pix_col} + (IMG_W + 1)'(1);
    assign pr1 = {1'b0, r_pix_row} + (IMG_W + 1)'(1);
    assign close_cell = (pc1 >= {1'b0, r_next_col}) && (pr1 >= {1'b0, r_next_row});
    assign wrap = pos_step && (pc1 >= {1'b0, eff_w}) && (pr1 >= {1'b0, eff_h});
    assign do_restart = (r_state == S_INIT) || (in_acc && i_frame_start) || wrap;

    // remainder stepping of the cell edges
    always_comb begin
        col_t  = {1'b0, r_col_rem} + {1'b0, r_wr};
        col_ge = (col_t >= {1'b0, eff_c});
        col_rem_stp = col_ge ? IMG_W'(col_t - {1'b0, eff_c}) : IMG_W'(col_t);
        cw_stp = r_wq + IMG_W'(col_ge);
        row_t  = {1'b0, r_row_rem} + {1'b0, r_hr};
        row_ge = (row_t >= {1'b0, eff_r});
        row_rem_stp = row_ge ? IMG_W'(row_t - {1'b0, eff_r}) : IMG_W'(row_t);
        ch_stp = r_hq + IMG_W'(row_ge);
    end

    always_comb begin
        n_pix_col  = r_pix_col;
        n_pix_row  = r_pix_row;
        n_cell_col = r_cell_col;
        n_cell_row = r_cell_row;
        n_col_rem  = r_col_rem;
        n_row_rem  = r_row_rem;
        n_cw_now   = r_cw_now;
        n_ch_now   = r_ch_now;
        n_next_col = r_next_col;
        n_next_row = r_next_row;
        if (pos_step) begin
            if (pc1 >= {1'b0, eff_w}) begin
                // end of a pixel row: maybe open a new cell row, then restart columns
                n_pix_row = IMG_W'(pr1);
                if (pr1 >= {1'b0, r_next_row}) begin
                    n_cell_row = r_cell_row + IMG_W'(1);
                    n_row_rem  = row_rem_stp;
                    n_ch_now   = ch_stp;
                    n_next_row = r_next_row + ch_stp;
                end
                n_pix_col  = '0;
                n_cell_col = '0;
                n_col_rem  = r_wr;
                n_cw_now   = r_wq;
                n_next_col = r_wq;
            end else begin
                n_pix_col = IMG_W'(pc1);
                if (pc1 >= {1'b0, r_next_col}) begin
                    n_cell_col = r_cell_col + CCOL_W'(1);
                    n_col_rem  = col_rem_stp;
                    n_cw_now   = cw_stp;
                    n_next_col = r_next_col + cw_stp;
                end
            end
        end
        if (do_restart) begin
            // first step from remainder zero: size is the plain quotient
            n_pix_col  = '0;
            n_pix_row  = '0;
            n_cell_col = '0;
            n_cell_row = '0;
            n_col_rem  = r_wr;
            n_row_rem  = r_hr;
            n_cw_now   = r_wq;
            n_ch_now   = r_hq;
            n_next_col = r_wq;
            n_next_row = r_hq;
        end
    end

    // line store of per-column sums; entries not written since restart read as zero
    logic              ram_we;
    logic [SUM_W-1:0]  ram_wdata, ram_rdata, prev_sum, sum_new;

    assign prev_sum  = r_valid[r_cell_col] ? ram_rdata : '0;
    assign sum_new   = prev_sum + SUM_W'(r_luma);
    assign ram_we    = pos_step;
    assign ram_wdata = close_cell ? '0 : sum_new;

    lbd_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_CELL_COLUMNS)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cell_col),
        .i_wdata (ram_wdata),
        .i_raddr (r_cell_col),
        .o_rdata (ram_rdata)
    );

    // shared divider: cell pitch at setup, ramp quotient per closed cell
    t_div_req         div_req;
    t_div_rsp         div_rsp;
    logic [DIV_W-1:0] div_num, div_den;
    logic [QB:0]      idx_diff;

    always_comb begin
        div_req.start = 1'b0;
        div_req.steps = STEP_W'(DIV_QW);
        div_num = DIV_W'(eff_w);
        div_den = DIV_W'(eff_c) << (DIV_QW - 1);
        case (r_state)
            S_PREPW: begin
                div_req.start = 1'b1;
            end
            S_PREPH: begin
                div_req.start = 1'b1;
                div_num = DIV_W'(eff_h);
                div_den = DIV_W'(eff_r) << (DIV_QW - 1);
            end
            S_DIV: begin
                // quotient of sum*L / (area << 16) is below L, so QB bits suffice
                div_req.start = 1'b1;
                div_req.steps = STEP_W'(QB);
                div_num = r_num;
                div_den = DIV_W'(r_area) << (GRAD_SHIFT + QB - 1);
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    lbd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_rsp   (div_rsp)
    );

    assign idx_diff = (QB + 1)'(RAMP_LEVELS - 1) - (QB + 1)'(div_rsp.quot[QB-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_PREPW;
            r_cfg_w     <= IMG_W'(1);
            r_cfg_h     <= IMG_W'(1);
            r_cfg_c     <= COLS_W'(1);
            r_cfg_r     <= IMG_W'(1);
            r_cfg_grad  <= 1'b1;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_pix_col   <= '0;
            r_pix_row   <= '0;
            r_cell_col  <= '0;
            r_cell_row  <= '0;
        end else begin
            r_pix_col  <= n_pix_col;
            r_pix_row  <= n_pix_row;
            r_cell_col <= n_cell_col;
            r_cell_row <= n_cell_row;

            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (pos_step) begin
                r_valid[r_cell_col] <= 1'b1;
            end
            if (do_restart) begin
                r_valid <= '0;
            end

            case (r_state)
                S_PREPW: r_state <= S_WAITW;
                S_WAITW: begin
                    if (div_rsp.done) begin
                        r_wq    <= div_rsp.quot;
                        r_wr    <= div_rsp.rem[IMG_W-1:0];
                        r_state <= S_PREPH;
                    end
                end
                S_PREPH: r_state <= S_WAITH;
                S_WAITH: begin
                    if (div_rsp.done) begin
                        r_hq    <= div_rsp.quot;
                        r_hr    <= div_rsp.rem[IMG_W-1:0];
                        r_state <= S_INIT;
                    end
                end
                S_INIT: r_state <= S_IDLE;
                S_IDLE: begin
                    if (in_acc) begin
                        r_luma  <= LUMA_W'(LUMA_R * i_red) + LUMA_W'(LUMA_G * i_green)
                                 + LUMA_W'(LUMA_B * i_blue);
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_area  <= AREA_W'(r_cw_now) * AREA_W'(r_ch_now);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (close_cell) begin
                        r_sum         <= sum_new;
                        r_row_end_p   <= (IMG_W'(r_cell_col) + IMG_W'(1)) >= eff_c;
                        r_frame_end_p <= ((IMG_W'(r_cell_col) + IMG_W'(1)) >= eff_c)
                                      && ({1'b0, r_cell_row} + (IMG_W + 1)'(1)
                                          >= {1'b0, eff_r});
                        if (r_cfg_grad) begin
                            r_state <= S_MUL;
                        end else begin
                            // mean below 64: sum < area * 256 * 64
                            r_idx <= (DIV_W'(sum_new) < (DIV_W'(r_area) << BIN_SHIFT))
                                   ? IDX_W'(RAMP_LEVELS - 1) : '0;
                            r_state <= S_RES;
                        end
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_MUL: begin
                    r_num   <= DIV_W'(r_sum) * DIV_W'(RAMP_LEVELS);
                    r_state <= S_DIV;
                end
                S_DIV: r_state <= S_DWT;
                S_DWT: begin
                    if (div_rsp.done) begin
                        r_idx   <= IDX_W'(idx_diff);
                        r_state <= S_RES;
                    end
                end
                S_RES: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_ramp      <= r_idx;
                        r_row_end   <= r_row_end_p;
                        r_frame_end <= r_frame_end_p;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_PREPW;
            endcase

            // register write: a mapped index takes effect at once and restarts the frame
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_IMAGE_WIDTH:   r_cfg_w    <= i_cfg_data;
                    REG_IMAGE_HEIGHT:  r_cfg_h    <= i_cfg_data;
                    REG_CELL_COLUMNS:  r_cfg_c    <= i_cfg_data[COLS_W-1:0];
                    REG_CELL_ROWS:     r_cfg_r    <= i_cfg_data;
                    REG_GRADIENT_MODE: r_cfg_grad <= i_cfg_data[0];
                    default: ;
                endcase
                if (cfg_hit) begin
                    r_state <= S_PREPW;
                end
            end
        end
    end

    // payload-only position registers
    always_ff @(posedge i_clk) begin
        r_col_rem  <= n_col_rem;
        r_row_rem  <= n_row_rem;
        r_cw_now   <= n_cw_now;
        r_ch_now   <= n_ch_now;
        r_next_col <= n_next_col;
        r_next_row <= n_next_row;
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_ramp_index = r_ramp;
    assign o_row_end    = r_row_end;
    assign o_frame_end  = r_frame_end;
endmodule

[rtl/lbd_checker.sv]
// Port-level checker for the luma box downsampler, bound to the top level.
`include "luma_box_downsample_to_ramp_macros.svh"

module lbd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic [7:0]                    i_red,
    input logic [7:0]                    i_green,
    input logic [7:0]                    i_blue,
    input logic                          i_frame_start,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [lbd_pkg::IDX_W-1:0]     o_ramp_index,
    input logic                          o_row_end,
    input logic                          o_frame_end,
    input logic                          i_cfg_we,
    input logic [lbd_pkg::CIDX_W-1:0]    i_cfg_index,
    input logic [lbd_pkg::CFG_W-1:0]     i_cfg_data
);
    import lbd_pkg::*;

    `LBD_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_ramp_index), "result dropped or changed while stalled")
    `LBD_ASSERT_IMP(a_frame_row, o_out_valid && o_frame_end, o_row_end, "frame end without row end")
    `LBD_ASSERT_IMP(a_idx_range, o_out_valid, o_ramp_index <= IDX_W'(RAMP_LEVELS - 1), "ramp index out of range")
    `LBD_ASSERT_NXT(a_busy_after_acc, i_in_valid && o_in_ready, !o_in_ready, "second pixel taken while busy")
    `LBD_ASSERT_NXT(a_cfg_setup, i_cfg_we && (i_cfg_index <= REG_GRADIENT_MODE), !o_in_ready, "pixel taken during pitch setup")
endmodule

bind luma_box_downsample_to_ramp lbd_checker u_lbd_checker (.*);

[verif/tb_luma_box_downsample_to_ramp.sv]
// Testbench for the luma box downsampler: directed and random pixel streams checked against a predictor.
module tb_luma_box_downsample_to_ramp;
    import lbd_pkg::*;

    // ------------------------------------------------------------------
    // Clock, reset and DUT signals
    // ------------------------------------------------------------------
    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [7:0]        i_red;
    logic [7:0]        i_green;
    logic [7:0]        i_blue;
    logic              i_frame_start;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [IDX_W-1:0]  o_ramp_index;
    logic              o_row_end;
    logic              o_frame_end;
    logic              i_cfg_we;
    logic [CIDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_data;

    // settle time after the last result before touching registers or ending
    localparam int DRAIN_CYCLES = 48;

    typedef struct {
        logic [IDX_W-1:0] ramp;
        logic             row_end;
        logic             frame_end;
    } t_cell_result;

    t_cell_result cells_due[$];   // predicted cells, oldest first
    int           fail_count;
    int           cells_seen;
    int           pixels_sent;
    int           cfg_phases;
    bit           no_idle;        // when set neither side stalls

    luma_box_downsample_to_ramp u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_frame_start (i_frame_start),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_ramp_index  (o_ramp_index),
        .o_row_end     (o_row_end),
        .o_frame_end   (o_frame_end),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    // ------------------------------------------------------------------
    // Predictor: register copies and grid walk state
    // ------------------------------------------------------------------
    int unsigned      img_w_reg, img_h_reg, cols_reg, rows_reg, grad_reg;
    longint unsigned  col_sum [MAX_CELL_COLUMNS];
    int unsigned      px_col, px_row, cl_col, cl_row;
    int unsigned      col_rem, row_rem, cell_w, cell_h;
    int unsigned      col_edge, row_edge;

    function automatic int unsigned clamp(int unsigned v, int unsigned lim);
        if (v < 1) v = 1;
        if (v > lim) v = lim;
        return v;
    endfunction

    function automatic int unsigned used_w();
        return clamp(img_w_reg, MAX_IMAGE_DIM);
    endfunction

    function automatic int unsigned used_h();
        return clamp(img_h_reg, MAX_IMAGE_DIM);
    endfunction

    function automatic int unsigned used_cols();
        int unsigned lim;
        lim = used_w();
        if (lim > MAX_CELL_COLUMNS) lim = MAX_CELL_COLUMNS;
        return clamp(cols_reg, lim);
    endfunction

    function automatic int unsigned used_rows();
        return clamp(rows_reg, used_h());
    endfunction

    // size of the next cell along an axis, remainder stepping
    function automatic int unsigned next_pitch(int unsigned size, int unsigned cells,
                                               inout int unsigned rem);
        int unsigned t;
        int unsigned w;
        w = size / cells;
        t = rem + size % cells;
        if (t >= cells) begin
            t -= cells;
            w++;
        end
        rem = t;
        return w;
    endfunction

    function automatic void begin_cell_row();
        cl_col   = 0;
        col_rem  = 0;
        cell_w   = next_pitch(used_w(), used_cols(), col_rem);
        col_edge = cell_w;
        px_col   = 0;
    endfunction

    function automatic void clear_grid();
        foreach (col_sum[i]) col_sum[i] = 0;
        px_row   = 0;
        cl_row   = 0;
        row_rem  = 0;
        cell_h   = next_pitch(used_h(), used_rows(), row_rem);
        row_edge = cell_h;
        begin_cell_row();
    endfunction

    function automatic void model_reg_write(int unsigned idx, int unsigned val);
        case (idx)
            REG_IMAGE_WIDTH:   img_w_reg = val & 13'h1fff;
            REG_IMAGE_HEIGHT:  img_h_reg = val & 13'h1fff;
            REG_CELL_COLUMNS:  cols_reg  = val & 9'h1ff;
            REG_CELL_ROWS:     rows_reg  = val & 13'h1fff;
            REG_GRADIENT_MODE: grad_reg  = val & 1;
            default: return;   // unmapped index: no effect, no restart
        endcase
        clear_grid();
    endfunction

    // accumulate one pixel; queue a cell when it is the cell's last pixel
    function automatic void predict_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                          logic fs);
        int unsigned     w, h, nc, nr, col;
        longint unsigned area, sum, lvl;
        t_cell_result    res;
        if (fs) clear_grid();
        w  = used_w();
        h  = used_h();
        nc = used_cols();
        nr = used_rows();
        col = (cl_col < MAX_CELL_COLUMNS) ? cl_col : MAX_CELL_COLUMNS - 1;
        col_sum[col] += LUMA_R * r + LUMA_G * g + LUMA_B * b;

        if (px_col + 1 >= col_edge && px_row + 1 >= row_edge) begin
            area = longint'(cell_w) * cell_h;
            if (area == 0) area = 1;
            sum = col_sum[col];
            if (grad_reg != 0)
                lvl = (RAMP_LEVELS - 1) - sum * RAMP_LEVELS / (65536 * area);
            else
                lvl = ((sum * 4 / (256 * area)) / 256 == 0) ? RAMP_LEVELS - 1 : 0;
            res.ramp      = lvl[IDX_W-1:0];
            res.row_end   = (cl_col + 1 >= nc);
            res.frame_end = (cl_col + 1 >= nc) && (cl_row + 1 >= nr);
            cells_due.push_back(res);
            col_sum[col] = 0;
        end

        if (px_col + 1 >= w) begin
            px_row++;
            if (px_row >= h) begin
                clear_grid();   // frame done: wrap without frame_start
                return;
            end
            if (px_row >= row_edge) begin
                cl_row++;
                cell_h = next_pitch(h, nr, row_rem);
                row_edge += cell_h;
            end
            begin_cell_row();
        end else begin
            px_col++;
            if (px_col >= col_edge) begin
                cl_col++;
                cell_w = next_pitch(w, nc, col_rem);
                col_edge += cell_w;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Stall lengths: mostly short, a few long
    // ------------------------------------------------------------------
    function automatic int unsigned pick_gap();
        if (no_idle) return 0;
        if ($urandom_range(0, 11) == 0) return $urandom_range(8, 40);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the checker
    // ------------------------------------------------------------------
    int unsigned ready_hold;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b1;
            ready_hold  <= 0;
        end else if (no_idle) begin
            i_out_ready <= 1'b1;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (i_out_ready) begin
            i_out_ready <= 1'b0;
            ready_hold  <= pick_gap();
        end else begin
            i_out_ready <= 1'b1;
            ready_hold  <= $urandom_range(0, 6);
        end
    end

    task automatic report_mismatch(string what, int got, int want);
        fail_count++;
        $display("mismatch at cell %0d: %s got %0d expected %0d", cells_seen, what, got, want);
    endtask

    // every output transaction is compared with the oldest predicted cell
    always @(posedge i_clk) begin
        t_cell_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (cells_due.size() == 0) begin
                report_mismatch("unexpected cell, ramp_index", o_ramp_index, -1);
            end else begin
                want = cells_due.pop_front();
                if (o_ramp_index !== want.ramp)
                    report_mismatch("ramp_index", o_ramp_index, want.ramp);
                if (o_row_end !== want.row_end)
                    report_mismatch("row_end", o_row_end, want.row_end);
                if (o_frame_end !== want.frame_end)
                    report_mismatch("frame_end", o_frame_end, want.frame_end);
            end
            cells_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Pixel side
    // ------------------------------------------------------------------
    // Valid stays high across back-to-back pixels; it drops only ahead of a gap.
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_red         <= r;
        i_green       <= g;
        i_blue        <= b;
        i_frame_start <= fs;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_pixel(r, g, b, fs);
        pixels_sent++;
    endtask

    task automatic send_gray(int unsigned n, logic [7:0] v);
        repeat (n) send_pixel(v, v, v, 1'b0);
    endtask

    // drop valid and wait until the block has nothing left in flight
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (cells_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        model_reg_write(idx, val);
    endtask

    // full register set, written only when idle
    task automatic configure(int unsigned w, int unsigned h, int unsigned c, int unsigned r,
                             bit grad);
        drain();
        write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
        write_reg(REG_CELL_COLUMNS, CFG_W'(c));
        write_reg(REG_CELL_ROWS, CFG_W'(r));
        // upper bits of the mode data are don't-care but still toggled
        write_reg(REG_GRADIENT_MODE, {12'($urandom_range(0, 4095)), grad});
        i_cfg_we <= 1'b0;
        cfg_phases++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // After reset: 1x1 image, one cell per pixel, gradient mode.
    task automatic test_reset_state();
        send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
        send_pixel(8'hff, 8'hff, 8'hff, 1'b0);
        send_pixel(8'hff, 8'h00, 8'h00, 1'b0);
        send_pixel(8'h00, 8'hff, 8'h00, 1'b0);
        send_pixel(8'h00, 8'h00, 8'hff, 1'b0);
    endtask

    // Zero sizes clamp up, oversized ones clamp down; partial frames end by a write.
    task automatic test_size_clamps();
        configure(0, 0, 0, 0, 1'b1);
        send_gray(2, 8'h80);
        configure(8191, 1, 511, 8191, 1'b1);   // 4096 wide, 256 cells of 16
        send_gray(20, 8'hff);
        configure(3, 8191, 511, 8191, 1'b1);   // columns clamp to width
        send_gray(6, 8'h40);
    endtask

    // Binary threshold right at mean 64, plus the frame wrap without frame_start.
    task automatic test_binary_threshold();
        configure(2, 2, 2, 2, 1'b0);
        send_pixel(8'd63, 8'd63, 8'd63, 1'b1);
        send_pixel(8'd64, 8'd64, 8'd64, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd65, 8'd65, 8'd65, 1'b0);   // wrapped to (0,0)
    endtask

    // frame_start in the middle of a frame throws away partial sums
    task automatic test_frame_restart();
        configure(4, 4, 2, 2, 1'b1);
        send_gray(5, 8'hff);
        send_pixel(8'h10, 8'h20, 8'h30, 1'b1);
        send_gray(3, 8'h00);
    endtask

    // Random register settings, mostly small grids sent as whole frames.
    task automatic test_random_frames(int unsigned target);
        int unsigned w, h, c, r, n, start_cnt;
        bit          whole;
        start_cnt = pixels_sent;
        while (pixels_sent - start_cnt < target) begin
            if ($urandom_range(0, 15) == 0) begin
                w = $urandom_range(0, 8191);
                h = $urandom_range(0, 8191);
                c = $urandom_range(0, 511);
                r = $urandom_range(0, 8191);
            end else begin
                w = $urandom_range(1, 24);
                h = $urandom_range(1, 10);
                c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
                                                : $urandom_range(0, w + 2);
                r = $urandom_range(0, h + 2);
            end
            configure(w, h, c, r, $urandom_range(0, 1));
            if ($urandom_range(0, 19) == 0) begin
                // unmapped index: block must ignore it
                @(posedge i_clk);
                write_reg(CIDX_W'($urandom_range(5, 7)), CFG_W'($urandom_range(0, 8191)));
                i_cfg_we <= 1'b0;
            end
            no_idle = ($urandom_range(0, 4) == 0);
            whole   = ($urandom_range(0, 5) != 0) && used_w() * used_h() <= 600;
            n = whole ? used_w() * used_h() * $urandom_range(1, 3) : $urandom_range(1, 60);
            for (int unsigned i = 0; i < n; i++) begin
                if (whole && i % (used_w() * used_h()) == 0)
                    send_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                               $urandom_range(0, 9) != 0);
                else
                    send_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                               $urandom_range(0, 49) == 0);
            end
            no_idle = 0;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        fail_count    = 0;
        cells_seen    = 0;
        pixels_sent   = 0;
        cfg_phases    = 0;
        no_idle       = 0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_red         = '0;
        i_green       = '0;
        i_blue        = '0;
        i_frame_start = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        img_w_reg     = 1;
        img_h_reg     = 1;
        cols_reg      = 1;
        rows_reg      = 1;
        grad_reg      = 1;
        clear_grid();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_size_clamps();
        test_binary_threshold();
        test_frame_restart();
        test_random_frames(1950);
        drain();

        $display("covered %0d pixels over %0d register settings, %0d cells checked",
                 pixels_sent, cfg_phases, cells_seen);
        $display("clamped sizes, binary threshold, mid-frame restarts and random stalls");
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(12 * 3000000);
        $display("FAILURE");
        $finish;
    end

endmodule

[luma_box_downsample_to_ramp.f]
+incdir+rtl
rtl/lbd_pkg.sv
rtl/lbd_ram.sv
rtl/lbd_div.sv
rtl/luma_box_downsample_to_ramp.sv
rtl/lbd_checker.sv
verif/tb_luma_box_downsample_to_ramp.sv
